### design/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared widths, codes and control types of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

    // field widths
    localparam int CLUSTER_W    = 12;
    localparam int IDX_W        = 13;
    localparam int BYTE_W       = 8;
    localparam int SECTOR_W     = 32;
    localparam int BOFF_W       = 48;
    localparam int TOTAL_W      = 32;
    localparam int BPS_W        = 16;
    localparam int SPC_W        = 8;
    localparam int FATN_W       = 8;
    localparam int HALF_W       = 16;

    // configuration port
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FATN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FATSZ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOTN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BPS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC      = 3'd6;

    localparam logic [SECTOR_W-1:0] RST_HIDDEN   = 32'd0;
    localparam logic [HALF_W-1:0]   RST_RESERVED = 16'd1;
    localparam logic [FATN_W-1:0]   RST_FATN     = 8'd2;
    localparam logic [HALF_W-1:0]   RST_FATSZ    = 16'd9;
    localparam logic [HALF_W-1:0]   RST_ROOTN    = 16'd224;
    localparam logic [BPS_W-1:0]    RST_BPS      = 16'd512;
    localparam logic [SPC_W-1:0]    RST_SPC      = 8'd1;

    // input action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    // chain constants
    localparam logic [CLUSTER_W-1:0] END_LIMIT          = 12'hFEF;
    localparam logic [SECTOR_W-1:0]  FIRST_DATA_CLUSTER = 32'd2;
    localparam int                   ROOT_ENTRY_SHIFT   = 5;
    localparam int                   ROOT_BYTES_W       = HALF_W + ROOT_ENTRY_SHIFT;

    // table index wrapping works on chunks of the smallest table size
    localparam int CHUNK_W = 9;
    localparam int CHUNKS  = 1 << (IDX_W - CHUNK_W);

    // parameter defaults
    localparam int TABLE_BYTES_DEF = 8192;
    localparam int MAX_CHAIN_DEF   = 64;

    typedef struct packed {
        logic load_wr;
        logic walk_start;
        logic base_load;
        logic read_en;
        logic calc_en;
    } fcw_cmd_t;

    typedef struct packed {
        logic div_done;
        logic s2_free;
        logic stop;
    } fcw_status_t;

endpackage

### design/fcw_if.sv
// ----------------------------------------------------------------------------
// fcw request and response channels
// Valid/ready channels carrying walker input items and chain results.
// ----------------------------------------------------------------------------
interface fcw_req_if;
    import fcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [IDX_W-1:0]     table_index;
    logic [BYTE_W-1:0]    table_byte;
    logic [CLUSTER_W-1:0] start_cluster;

    modport source (output valid, action, table_index, table_byte, start_cluster,
                    input ready);
    modport sink   (input valid, action, table_index, table_byte, start_cluster,
                    output ready);
endinterface

interface fcw_rsp_if;
    import fcw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CLUSTER_W-1:0] cluster;
    logic [SECTOR_W-1:0]  sector;
    logic [BOFF_W-1:0]    byte_offset;
    logic [TOTAL_W-1:0]   bytes_total;
    logic                 last;
    logic                 truncated;

    modport source (output valid, cluster, sector, byte_offset, bytes_total, last,
                    truncated, input ready);
    modport sink   (input valid, cluster, sector, byte_offset, bytes_total, last,
                    truncated, output ready);
endinterface

### design/fcw_div.sv
// ----------------------------------------------------------------------------
// fcw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcw_div #(
    parameter int DIVIDEND_W = fcw_pkg::ROOT_BYTES_W,
    parameter int DIVISOR_W  = fcw_pkg::BPS_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg, done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;

    // dividend bits shift out at the top while quotient bits shift in below
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor};
        ge       = ~diff[DIVISOR_W+1];
        rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/fcw_ctrl.sv
// ----------------------------------------------------------------------------
// fcw_ctrl
// Sequencer for table loads and chain walks.
// ----------------------------------------------------------------------------
module fcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_action,
    output logic                req_ready,
    input  fcw_pkg::fcw_status_t status,
    output fcw_pkg::fcw_cmd_t    cmd
);
    import fcw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_BASE = 5'b00100,
        ST_READ = 5'b01000,
        ST_CALC = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_action == ACT_WALK)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_DIV;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base_load = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = ST_CALC;
            end
            ST_CALC:
            begin
                // hold until the result stage can take this step
                if (status.s2_free)
                begin
                    cmd.calc_en = 1'b1;
                    state_next  = status.stop ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/fcw_dp.sv
// ----------------------------------------------------------------------------
// fcw_dp
// Config registers, table memory, sector arithmetic and result pipe.
// ----------------------------------------------------------------------------
module fcw_dp #(
    parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcw_pkg::CFG_W-1:0]      cfg_wdata,
    input  fcw_pkg::fcw_cmd_t              cmd,
    output fcw_pkg::fcw_status_t           status,
    input  logic [fcw_pkg::IDX_W-1:0]      table_index,
    input  logic [fcw_pkg::BYTE_W-1:0]     table_byte,
    input  logic [fcw_pkg::CLUSTER_W-1:0]  start_cluster,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [fcw_pkg::CLUSTER_W-1:0]  cluster,
    output logic [fcw_pkg::SECTOR_W-1:0]   sector,
    output logic [fcw_pkg::BOFF_W-1:0]     byte_offset,
    output logic [fcw_pkg::TOTAL_W-1:0]    bytes_total,
    output logic                           last,
    output logic                           truncated
);
    import fcw_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_BYTES);
    localparam int SUM_W  = IDX_W + 1;
    localparam int CNT_W  = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int FCP_W  = FATN_W + HALF_W;
    localparam int PCL_W  = SPC_W + BPS_W;
    localparam int PRD_W  = SECTOR_W + SPC_W;

    // residue of each table-size chunk start, so an index wraps with one add and at most one subtract
    function automatic logic [CHUNKS-1:0][IDX_W-1:0] wrap_table();
        logic [CHUNKS-1:0][IDX_W-1:0] t;
        for (int h = 0; h < CHUNKS; h++)
        begin
            t[h] = IDX_W'((h << CHUNK_W) % TABLE_BYTES);
        end
        return t;
    endfunction

    localparam logic [CHUNKS-1:0][IDX_W-1:0] WRAP_TBL = wrap_table();

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [IDX_W-1:0] x);
        logic [SUM_W-1:0] s;
        s = {1'b0, WRAP_TBL[x[IDX_W-1:CHUNK_W]]} + SUM_W'(x[CHUNK_W-1:0]);
        if (s >= SUM_W'(TABLE_BYTES))
        begin
            s = s - SUM_W'(TABLE_BYTES);
        end
        return s[ADDR_W-1:0];
    endfunction

    // configuration
    logic [SECTOR_W-1:0] hidden_reg;
    logic [HALF_W-1:0]   reserved_reg;
    logic [FATN_W-1:0]   fatn_reg;
    logic [HALF_W-1:0]   fatsz_reg;
    logic [HALF_W-1:0]   rootn_reg;
    logic [BPS_W-1:0]    bps_reg;
    logic [SPC_W-1:0]    spc_reg;

    // derived terms, refreshed every cycle from the config registers
    logic [SECTOR_W-1:0] hr_sum_reg;
    logic [FCP_W-1:0]    fat_prod_reg;
    logic [SECTOR_W-1:0] part_reg;
    logic [PCL_W-1:0]    per_cluster_reg;

    // walk state
    logic [CLUSTER_W-1:0] clus_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [SECTOR_W-1:0]  base_reg;
    logic [SECTOR_W-1:0]  prod_reg;
    logic [BYTE_W-1:0]    rd_lo_reg, rd_hi_reg;

    // result stage and output register
    logic                 s2_valid_reg, s2_valid_next;
    logic [CLUSTER_W-1:0] s2_cluster_reg;
    logic [SECTOR_W-1:0]  s2_sector_reg;
    logic [TOTAL_W-1:0]   s2_total_reg;
    logic                 s2_last_reg, s2_trunc_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [CLUSTER_W-1:0] out_cluster_reg;
    logic [SECTOR_W-1:0]  out_sector_reg;
    logic [BOFF_W-1:0]    out_boff_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic                 out_last_reg, out_trunc_reg;

    logic [BYTE_W-1:0]       mem [TABLE_BYTES];

    logic [ROOT_BYTES_W-1:0] root_bytes;
    logic [ROOT_BYTES_W-1:0] quot;
    logic                    div_done;
    logic [SECTOR_W-1:0]     root_sectors;
    logic [IDX_W-1:0]        rd_off, rd_off1;
    logic [ADDR_W-1:0]       wr_addr, rd_addr0, rd_addr1;
    logic [2*BYTE_W-1:0]     word;
    logic [CLUSTER_W-1:0]    nxt;
    logic                    ends, capped;
    logic [SECTOR_W-1:0]     clus_m2;
    logic [PRD_W-1:0]        prod_full;
    logic [TOTAL_W-1:0]      total_sum;
    logic                    s2_drain;

    assign root_bytes = {rootn_reg, ROOT_ENTRY_SHIFT'(0)};

    fcw_div #(
        .DIVIDEND_W (ROOT_BYTES_W),
        .DIVISOR_W  (BPS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.walk_start),
        .dividend (root_bytes),
        .divisor  (bps_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // zero bytes per sector drops the root directory term
    assign root_sectors = (bps_reg == '0) ? '0 : SECTOR_W'(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidden_reg   <= RST_HIDDEN;
            reserved_reg <= RST_RESERVED;
            fatn_reg     <= RST_FATN;
            fatsz_reg    <= RST_FATSZ;
            rootn_reg    <= RST_ROOTN;
            bps_reg      <= RST_BPS;
            spc_reg      <= RST_SPC;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIDDEN:   hidden_reg   <= cfg_wdata[SECTOR_W-1:0];
                CFG_RESERVED: reserved_reg <= cfg_wdata[HALF_W-1:0];
                CFG_FATN:     fatn_reg     <= cfg_wdata[FATN_W-1:0];
                CFG_FATSZ:    fatsz_reg    <= cfg_wdata[HALF_W-1:0];
                CFG_ROOTN:    rootn_reg    <= cfg_wdata[HALF_W-1:0];
                CFG_BPS:      bps_reg      <= cfg_wdata[BPS_W-1:0];
                CFG_SPC:      spc_reg      <= cfg_wdata[SPC_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        hr_sum_reg      <= hidden_reg + SECTOR_W'(reserved_reg);
        fat_prod_reg    <= FCP_W'(fatn_reg) * FCP_W'(fatsz_reg);
        part_reg        <= hr_sum_reg + SECTOR_W'(fat_prod_reg);
        per_cluster_reg <= PCL_W'(spc_reg) * PCL_W'(bps_reg);
    end

    // table access
    assign rd_off   = IDX_W'(clus_reg) + IDX_W'(clus_reg >> 1);
    assign rd_off1  = rd_off + 1'b1;
    assign wr_addr  = wrap_addr(table_index);
    assign rd_addr0 = wrap_addr(rd_off);
    assign rd_addr1 = wrap_addr(rd_off1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            mem[wr_addr] <= table_byte;
        end
        if (cmd.read_en)
        begin
            rd_lo_reg <= mem[rd_addr0];
            rd_hi_reg <= mem[rd_addr1];
        end
    end

    // next entry: low 12 bits for an even cluster, high 12 for an odd one
    always_comb
    begin
        word      = {rd_hi_reg, rd_lo_reg};
        nxt       = clus_reg[0] ? word[2*BYTE_W-1:4] : word[CLUSTER_W-1:0];
        ends      = (nxt > END_LIMIT);
        capped    = ~ends && (cnt_reg == CNT_W'(MAX_CHAIN - 1));
        clus_m2   = SECTOR_W'(clus_reg) - FIRST_DATA_CLUSTER;
        prod_full = PRD_W'(clus_m2) * PRD_W'(spc_reg);
        total_sum = total_reg + TOTAL_W'(per_cluster_reg);
    end

    assign s2_drain       = s2_valid_reg && (~out_valid_reg || rsp_ready);
    assign s2_valid_next  = cmd.calc_en ? 1'b1 : (s2_drain ? 1'b0 : s2_valid_reg);
    assign out_valid_next = s2_drain ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (cmd.walk_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.calc_en && ~(ends || capped))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            clus_reg  <= start_cluster;
            total_reg <= '0;
        end
        else if (cmd.calc_en)
        begin
            clus_reg  <= nxt;
            total_reg <= total_sum;
        end
        if (cmd.base_load)
        begin
            base_reg <= part_reg + root_sectors;
        end
        if (cmd.read_en)
        begin
            prod_reg <= prod_full[SECTOR_W-1:0];
        end
        if (cmd.calc_en)
        begin
            s2_cluster_reg <= clus_reg;
            s2_sector_reg  <= base_reg + prod_reg;
            s2_total_reg   <= total_sum;
            s2_last_reg    <= ends || capped;
            s2_trunc_reg   <= capped;
        end
        if (s2_drain)
        begin
            out_cluster_reg <= s2_cluster_reg;
            out_sector_reg  <= s2_sector_reg;
            out_boff_reg    <= BOFF_W'(s2_sector_reg) * BOFF_W'(bps_reg);
            out_total_reg   <= s2_total_reg;
            out_last_reg    <= s2_last_reg;
            out_trunc_reg   <= s2_trunc_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.s2_free  = ~s2_valid_reg || s2_drain;
    assign status.stop     = ends || capped;

    assign rsp_valid   = out_valid_reg;
    assign cluster     = out_cluster_reg;
    assign sector      = out_sector_reg;
    assign byte_offset = out_boff_reg;
    assign bytes_total = out_total_reg;
    assign last        = out_last_reg;
    assign truncated   = out_trunc_reg;

    a_calc_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc_en |-> (~s2_valid_reg || s2_drain))
        else $error("chain step issued while result stage is full");

    a_calc_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc_en |=> s2_valid_reg)
        else $error("chain step did not reach result stage");

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_trunc_reg) |-> out_last_reg)
        else $error("truncated result not marked last");

endmodule

### design/fat12_cluster_chain_walker.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Walks FAT12 cluster chains over a local table copy and reports data sectors.
// ----------------------------------------------------------------------------
// A load item (action 0) writes one table byte; loads can follow each other
// every cycle while no walk is running. A walk item (action 1) first divides
// the root directory size by bytes_per_sector, one quotient bit per cycle, and
// then handles each chain cluster with one table read of both entry bytes on
// the two memory read ports and one step of sector arithmetic, which waits
// while the result stage is full. Results leave through a result stage and
// an output register, so the walk runs on while up to two results wait.
// The next item is taken once the last step of a walk is issued. The table
// memory is not cleared; reading a byte that was never loaded gives an
// undefined entry. A chain reports at most MAX_CHAIN clusters.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
    parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcw_pkg::CFG_W-1:0]     cfg_wdata,
    fcw_req_if.sink                       req,
    fcw_rsp_if.source                     rsp
);
    import fcw_pkg::*;

    fcw_cmd_t    cmd;
    fcw_status_t status;

    fcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .status     (status),
        .cmd        (cmd)
    );

    fcw_dp #(
        .TABLE_BYTES (TABLE_BYTES),
        .MAX_CHAIN   (MAX_CHAIN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status),
        .table_index   (req.table_index),
        .table_byte    (req.table_byte),
        .start_cluster (req.start_cluster),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .cluster       (rsp.cluster),
        .sector        (rsp.sector),
        .byte_offset   (rsp.byte_offset),
        .bytes_total   (rsp.bytes_total),
        .last          (rsp.last),
        .truncated     (rsp.truncated)
    );

endmodule

### tb/sv/fat12_cluster_chain_walker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_tb
// Fills the walker's allocation table with byte loads, builds cluster chains
// and walks them under several volume geometries. Every chain result is
// predicted from a shadow copy of the table and checked field by field.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_tb;
    import fcw_pkg::*;

    localparam int TABLE_SIZE    = TABLE_BYTES_DEF;
    localparam int CHAIN_CAP     = MAX_CHAIN_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int GAP_PERCENT   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [CLUSTER_W-1:0] EOC_LOW    = 12'hFF0;
    localparam logic [CLUSTER_W-1:0] EOC_HIGH   = 12'hFFF;

    typedef struct packed {
        logic [SECTOR_W-1:0] hidden;
        logic [HALF_W-1:0]   reserved;
        logic [FATN_W-1:0]   fatn;
        logic [HALF_W-1:0]   fatsz;
        logic [HALF_W-1:0]   rootn;
        logic [BPS_W-1:0]    bps;
        logic [SPC_W-1:0]    spc;
    } volume_geom_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [SECTOR_W-1:0]  sector;
        logic [BOFF_W-1:0]    byte_offset;
        logic [TOTAL_W-1:0]   bytes_total;
        logic                 last;
        logic                 truncated;
    } chain_step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    fcw_req_if req_ch ();
    fcw_rsp_if rsp_ch ();

    fat12_cluster_chain_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow of the table, with a mark for every byte loaded so far
    logic [BYTE_W-1:0] fat_copy [TABLE_SIZE];
    bit                fat_known [TABLE_SIZE];
    volume_geom_t      geom;
    chain_step_t       walk_steps[$];
    chain_step_t       cluster_reports_due[$];
    int                mismatch_count = 0;
    int                items_issued = 0;
    bit                no_gaps = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result sink with random stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // walks the shadow table from start and fills walk_steps; returns the first
    // table byte that was never loaded, or -1 when the whole chain is defined
    function automatic int predict_chain(input logic [CLUSTER_W-1:0] start);
        logic [CLUSTER_W-1:0] clus;
        logic [CLUSTER_W-1:0] nxt;
        logic [SECTOR_W-1:0]  base;
        logic [SECTOR_W-1:0]  sec;
        logic [TOTAL_W-1:0]   per_clus;
        logic [TOTAL_W-1:0]   total;
        logic [IDX_W-1:0]     off;
        logic [IDX_W-1:0]     off1;
        logic [15:0]          word;
        logic                 ends;
        logic                 capped;
        chain_step_t          st;
        int                   n;
        bit                   done;
        walk_steps.delete();
        base = geom.hidden + geom.reserved + geom.fatn * geom.fatsz;
        if (geom.bps != 0)
            base = base + ({geom.rootn, 5'b0} / geom.bps);
        per_clus = geom.spc * geom.bps;
        total = '0;
        clus = start;
        n = 0;
        done = 1'b0;
        while (!done)
        begin
            sec = base + (SECTOR_W'(clus) - FIRST_DATA_CLUSTER) * geom.spc;
            off = {1'b0, clus} + IDX_W'(clus >> 1);
            off1 = off + 1'b1;
            if (!fat_known[off])
                return int'(off);
            if (!fat_known[off1])
                return int'(off1);
            word = {fat_copy[off1], fat_copy[off]};
            nxt = clus[0] ? word[15:4] : word[11:0];
            ends = nxt > END_LIMIT;
            capped = !ends && (n + 1 >= CHAIN_CAP);
            total = total + per_clus;
            st.cluster = clus;
            st.sector = sec;
            st.byte_offset = BOFF_W'(sec) * BOFF_W'(geom.bps);
            st.bytes_total = total;
            st.last = ends || capped;
            st.truncated = capped;
            walk_steps.push_back(st);
            n++;
            done = ends || capped;
            clus = nxt;
        end
        return -1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        chain_step_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (cluster_reports_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual cluster %0h",
                         $time, rsp_ch.cluster);
                mismatch_count++;
            end
            else
            begin
                want = cluster_reports_due.pop_front();
                check_field("cluster", want.cluster, rsp_ch.cluster);
                check_field("sector", want.sector, rsp_ch.sector);
                check_field("byte_offset", want.byte_offset, rsp_ch.byte_offset);
                check_field("bytes_total", want.bytes_total, rsp_ch.bytes_total);
                check_field("last", want.last, rsp_ch.last);
                check_field("truncated", want.truncated, rsp_ch.truncated);
            end
        end
    end

    // one transfer on the request channel; valid stays up for a following item
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val,
                             input logic [CLUSTER_W-1:0] start);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.table_index   <= idx;
        req_ch.table_byte    <= val;
        req_ch.start_cluster <= start;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (act == ACT_LOAD)
        begin
            fat_copy[idx]  = val;
            fat_known[idx] = 1'b1;
        end
        else
        begin
            foreach (walk_steps[i])
                cluster_reports_due.push_back(walk_steps[i]);
        end
        items_issued++;
    endtask

    task automatic load_byte(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        send_item(ACT_LOAD, idx, val, CLUSTER_W'($urandom));
    endtask

    // read-modify-write of the two bytes that hold one 12-bit entry
    task automatic set_entry(input logic [CLUSTER_W-1:0] clus,
                             input logic [CLUSTER_W-1:0] val);
        logic [IDX_W-1:0]  off;
        logic [IDX_W-1:0]  off1;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        off = {1'b0, clus} + IDX_W'(clus >> 1);
        off1 = off + 1'b1;
        lo = fat_known[off] ? fat_copy[off] : BYTE_W'($urandom);
        hi = fat_known[off1] ? fat_copy[off1] : BYTE_W'($urandom);
        if (!clus[0])
        begin
            lo = val[7:0];
            hi = {hi[7:4], val[11:8]};
        end
        else
        begin
            lo = {val[3:0], lo[3:0]};
            hi = val[11:4];
        end
        load_byte(off, lo);
        load_byte(off1, hi);
    endtask

    // bytes on the path that were never loaded get a value first
    task automatic walk_from(input logic [CLUSTER_W-1:0] start);
        int miss;
        miss = predict_chain(start);
        while (miss >= 0)
        begin
            load_byte(IDX_W'(miss),
                      ($urandom_range(3) == 0) ? 8'hFF : BYTE_W'($urandom));
            miss = predict_chain(start);
        end
        send_item(ACT_WALK, IDX_W'($urandom), BYTE_W'($urandom), start);
    endtask

    task automatic build_chain(input logic [CLUSTER_W-1:0] start, input int len,
                               input bit linear);
        logic [CLUSTER_W-1:0] cur;
        logic [CLUSTER_W-1:0] nxt;
        cur = start;
        for (int i = 0; i < len - 1; i++)
        begin
            nxt = linear ? cur + 1'b1 : CLUSTER_W'($urandom_range(END_LIMIT));
            set_entry(cur, nxt);
            cur = nxt;
        end
        set_entry(cur, CLUSTER_W'($urandom_range(EOC_LOW, EOC_HIGH)));
        walk_from(start);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (cluster_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_poke(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
    endtask

    // only called with the walker idle
    task automatic apply_config(input volume_geom_t g);
        geom = g;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        cfg_poke(CFG_HIDDEN, g.hidden);
        cfg_poke(CFG_RESERVED, CFG_W'(g.reserved));
        cfg_poke(CFG_FATN, CFG_W'(g.fatn));
        cfg_poke(CFG_FATSZ, CFG_W'(g.fatsz));
        cfg_poke(CFG_ROOTN, CFG_W'(g.rootn));
        cfg_poke(CFG_BPS, CFG_W'(g.bps));
        cfg_poke(CFG_SPC, CFG_W'(g.spc));
        // the spare index must leave every register alone
        cfg_poke(CFG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic volume_geom_t rand_geom();
        volume_geom_t g;
        g.hidden   = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : SECTOR_W'($urandom);
        g.reserved = HALF_W'($urandom);
        g.fatn     = FATN_W'($urandom);
        g.fatsz    = HALF_W'($urandom);
        g.rootn    = HALF_W'($urandom);
        g.bps      = ($urandom_range(3) == 0) ? RST_BPS : BPS_W'($urandom_range(1, 65535));
        g.spc      = SPC_W'($urandom_range(1, 255));
        return g;
    endfunction

    task automatic test_reset_geometry();
        load_byte(13'h1FFF, 8'hFF);
        load_byte(13'h0000, 8'h00);
        build_chain(12'd2, 3, 1'b1);
        // clusters below two wrap in the sector sum
        set_entry(12'd0, 12'd2);
        walk_from(12'd0);
        set_entry(12'd1, EOC_HIGH);
        walk_from(12'd1);
    endtask

    task automatic test_entry_limits();
        // the highest continuing entry, then the lowest end marker
        set_entry(12'd10, END_LIMIT);
        set_entry(END_LIMIT, EOC_LOW);
        walk_from(12'd10);
        // reserved start clusters are still reported
        set_entry(EOC_HIGH, 12'd10);
        walk_from(EOC_HIGH);
        set_entry(EOC_LOW, EOC_HIGH);
        walk_from(EOC_LOW);
    endtask

    task automatic test_chain_cap();
        // a chain that ends exactly at the cap, then one cluster longer
        build_chain(12'd100, CHAIN_CAP, 1'b1);
        set_entry(12'd99, 12'd100);
        walk_from(12'd99);
        set_entry(12'd20, 12'd20);
        walk_from(12'd20);
    endtask

    task automatic test_geometry_extremes();
        volume_geom_t g;
        wait_drain();
        g.hidden = 32'hFFFF_FFFF;
        g.reserved = 16'hFFFF;
        g.fatn = 8'hFF;
        g.fatsz = 16'hFFFF;
        g.rootn = 16'hFFFF;
        g.bps = 16'hFFFF;
        g.spc = 8'hFF;
        apply_config(g);
        walk_from(12'd2);
        walk_from(12'd0);
        walk_from(12'd99);
        wait_drain();
        // zero bytes per sector drops the root directory term
        g = '0;
        g.rootn = 16'hFFFF;
        g.spc = 8'd1;
        apply_config(g);
        walk_from(12'd2);
        walk_from(EOC_HIGH);
        wait_drain();
        g.bps = 16'd1;
        g.spc = 8'hFF;
        apply_config(g);
        walk_from(12'd10);
        walk_from(12'd1);
    endtask

    task automatic test_random_traffic(input int goal, input bit steady);
        int stop_at;
        int pick;
        int len;
        wait_drain();
        apply_config(rand_geom());
        no_gaps = steady;
        stop_at = items_issued + goal;
        while (items_issued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                len = $urandom_range(99);
                if (len < 75)
                    len = $urandom_range(1, 6);
                else if (len < 95)
                    len = $urandom_range(7, 30);
                else
                    len = $urandom_range(CHAIN_CAP - 14, CHAIN_CAP + 6);
                build_chain(CLUSTER_W'($urandom), len, 1'b0);
            end
            else if (pick < 70)
                walk_from(CLUSTER_W'($urandom));
            else
                load_byte(IDX_W'($urandom), BYTE_W'($urandom));
            // hold the sender until the walker has emptied out
            if ($urandom_range(99) < 4)
                wait_drain();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_LOAD;
        req_ch.table_index = '0;
        req_ch.table_byte = '0;
        req_ch.start_cluster = '0;
        geom.hidden = RST_HIDDEN;
        geom.reserved = RST_RESERVED;
        geom.fatn = RST_FATN;
        geom.fatsz = RST_FATSZ;
        geom.rootn = RST_ROOTN;
        geom.bps = RST_BPS;
        geom.spc = RST_SPC;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_geometry();
        test_entry_limits();
        test_chain_cap();
        test_geometry_extremes();
        test_random_traffic(15, 1'b0);
        test_random_traffic(10, 1'b1);
        test_random_traffic(15, 1'b0);
        wait_drain();

        if (mismatch_count == 0 && cluster_reports_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
